// File: src/sbtwd_pkg.sv
// Shared types and constants for the six-bit text word decoder.
// No dependencies; imported by the controller, datapath and top level.
`default_nettype none
package sbtwd_pkg;

    localparam int C_CODE_W    = 6;
    localparam int C_NUM_CODES = 5;
    localparam int C_WORD_W    = C_CODE_W * C_NUM_CODES;
    localparam int C_IDX_W     = 3;

    localparam logic [6:0] C_TAB_CHAR   = 7'h09;
    localparam logic [6:0] C_NL_CHAR    = 7'h0A;
    localparam logic [6:0] C_SPACE_CHAR = 7'h20;

    localparam logic [7:0] C_COL_START  = 8'd1;
    localparam logic [7:0] C_STOP_STEP  = 8'd8;
    localparam logic [7:0] C_STOP_MAX   = 8'd255;
    localparam logic [1:0] C_STOP_LAST_FIXED = 2'd2;

    localparam logic [7:0] C_FIXED_STOPS [0:2] = '{8'd13, 8'd27, 8'd43};

    localparam logic [6:0] C_CODE_TABLE [0:63] = '{
        7'h5B, 7'h25, 7'h5D, 7'h21, 7'h26, 7'h2A, 7'h3A, 7'h5F,
        7'h2B, 7'h09, 7'h3F, 7'h22, 7'h27, 7'h0A, 7'h28, 7'h29,
        7'h30, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37,
        7'h38, 7'h39, 7'h3B, 7'h3D, 7'h2C, 7'h2D, 7'h2E, 7'h2F,
        7'h20, 7'h41, 7'h42, 7'h43, 7'h44, 7'h45, 7'h46, 7'h47,
        7'h48, 7'h49, 7'h4A, 7'h4B, 7'h4C, 7'h4D, 7'h4E, 7'h4F,
        7'h50, 7'h51, 7'h52, 7'h53, 7'h54, 7'h55, 7'h56, 7'h57,
        7'h58, 7'h59, 7'h5A, 7'h24, 7'h23, 7'h40, 7'h5E, 7'h62
    };

    typedef struct packed {
        logic [6:0] char_code;
        logic       char_valid;
        logic       newline_seen;
        logic [7:0] column_after;
        logic       last;
    } t_result;

    typedef struct packed {
        logic load;
        logic step;
        logic flush;
    } t_ctrl_cmd;

    typedef struct packed {
        logic done;
        logic cand_valid;
        logic hold_valid;
        logic out_free;
    } t_dp_status;

endpackage
`default_nettype wire

// File: src/sbtwd_ctrl.sv
// Sequencer for the six-bit text word decoder: load, step per code, flush.
// Depends on sbtwd_pkg for the command and status structs.
`default_nettype none
module sbtwd_ctrl
    import sbtwd_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_in_valid,
    output logic       o_in_ready,
    input  wire t_dp_status i_status,
    output t_ctrl_cmd  o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_END  = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_RUN;
                end
            end
            S_RUN: begin
                if (i_status.done) begin
                    n_state = S_END;
                end else begin
                    // a new beat needs the held beat to move on
                    o_cmd.step = !(i_status.cand_valid && i_status.hold_valid
                                   && !i_status.out_free);
                end
            end
            S_END: begin
                if (i_status.out_free) begin
                    o_cmd.flush = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
`default_nettype wire

// File: src/sbtwd_datapath.sv
// Datapath for the six-bit text word decoder: column and tab-stop state,
// code lookup, hold stage for the last flag and output register. Uses sbtwd_pkg.
`default_nettype none
module sbtwd_datapath
    import sbtwd_pkg::*;
#(
    parameter int COLUMN_LIMIT = 255
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire t_ctrl_cmd      i_cmd,
    output t_dp_status          o_status,
    input  wire [C_WORD_W-1:0]  i_word,
    input  wire                 i_line_start,
    input  wire                 i_cfg_wr_en,
    input  wire                 i_cfg_wr_data,
    input  wire                 i_out_ready,
    output logic                o_out_valid,
    output t_result             o_out
);

    localparam logic [7:0] COL_MAX = 8'(COLUMN_LIMIT);

    logic [C_WORD_W-1:0] r_word;
    logic [C_IDX_W-1:0]  r_idx;
    logic                r_pad;
    logic                r_nl_done;
    logic [7:0]          r_col;
    logic [7:0]          r_stop;
    logic [1:0]          r_stop_idx;
    logic                r_expand;
    t_result             r_hold;
    logic                r_hold_valid;
    t_result             r_out;
    logic                r_out_valid;

    logic [C_CODE_W-1:0] code;
    logic [6:0]          ch;
    logic [7:0]          col_inc;
    logic [8:0]          stop_sum;
    logic [7:0]          n_stop;
    logic [1:0]          n_stop_idx;
    logic                can_pad;
    logic                cand_valid;
    t_result             cand;
    logic [7:0]          n_col;
    logic                n_pad;
    logic                n_nl_done;
    logic                adv_code;
    logic                adv_stop;
    logic                out_free;
    t_result             flush_res;

    assign code     = r_word[C_WORD_W-1 -: C_CODE_W];
    assign ch       = C_CODE_TABLE[code];
    assign col_inc  = (r_col < COL_MAX) ? r_col + 8'd1 : r_col;
    assign stop_sum = {1'b0, r_stop} + {1'b0, C_STOP_STEP};
    assign can_pad  = (r_col < r_stop) && (r_col < COL_MAX);
    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        if (r_stop_idx < C_STOP_LAST_FIXED) begin
            n_stop_idx = r_stop_idx + 2'd1;
            n_stop     = C_FIXED_STOPS[n_stop_idx];
        end else begin
            n_stop_idx = r_stop_idx;
            n_stop     = stop_sum[8] ? C_STOP_MAX : stop_sum[7:0];
        end
    end

    always_comb begin
        cand       = '0;
        cand_valid = 1'b0;
        n_col      = r_col;
        n_pad      = r_pad;
        n_nl_done  = r_nl_done;
        adv_code   = 1'b0;
        adv_stop   = 1'b0;
        if (r_pad) begin
            if (can_pad) begin
                cand_valid = 1'b1;
                n_col      = col_inc;
                cand.char_code = C_SPACE_CHAR;
            end else begin
                adv_stop = 1'b1;
                adv_code = 1'b1;
                n_pad    = 1'b0;
            end
        end else if (ch == C_TAB_CHAR && r_expand) begin
            n_pad = 1'b1;
        end else if (ch == C_NL_CHAR) begin
            cand_valid        = 1'b1;
            n_col             = C_COL_START;
            n_nl_done         = 1'b1;
            cand.char_code    = ch;
            cand.newline_seen = 1'b1;
        end else begin
            cand_valid     = 1'b1;
            n_col          = col_inc;
            adv_code       = 1'b1;
            cand.char_code = ch;
        end
        cand.char_valid   = 1'b1;
        cand.column_after = n_col;
        cand.last         = 1'b0;
    end

    always_comb begin
        if (r_hold_valid) begin
            flush_res      = r_hold;
            flush_res.last = 1'b1;
        end else begin
            flush_res              = '0;
            flush_res.column_after = r_col;
            flush_res.last         = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col        <= C_COL_START;
            r_stop       <= C_FIXED_STOPS[0];
            r_stop_idx   <= 2'd0;
            r_expand     <= 1'b1;
            r_idx        <= '0;
            r_pad        <= 1'b0;
            r_nl_done    <= 1'b0;
            r_hold_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_expand <= i_cfg_wr_data;
            end
            if (i_cmd.load) begin
                r_idx     <= '0;
                r_pad     <= 1'b0;
                r_nl_done <= 1'b0;
                if (i_line_start || r_col <= C_COL_START) begin
                    r_col      <= C_COL_START;
                    r_stop_idx <= 2'd0;
                    r_stop     <= C_FIXED_STOPS[0];
                end
            end
            if (i_cmd.step) begin
                r_col     <= n_col;
                r_pad     <= n_pad;
                r_nl_done <= n_nl_done;
                if (adv_code) begin
                    r_idx <= r_idx + 3'd1;
                end
                if (adv_stop) begin
                    r_stop     <= n_stop;
                    r_stop_idx <= n_stop_idx;
                end
                if (cand_valid) begin
                    r_hold_valid <= 1'b1;
                end
            end
            if (i_cmd.flush) begin
                r_hold_valid <= 1'b0;
            end
            if ((i_cmd.step && cand_valid && r_hold_valid) || i_cmd.flush) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_word <= i_word;
        end else if (i_cmd.step && adv_code) begin
            r_word <= {r_word[C_WORD_W-C_CODE_W-1:0], {C_CODE_W{1'b0}}};
        end
        if (i_cmd.step && cand_valid) begin
            r_hold <= cand;
        end
        if (i_cmd.step && cand_valid && r_hold_valid) begin
            r_out <= r_hold;
        end else if (i_cmd.flush) begin
            r_out <= flush_res;
        end
    end

    assign o_status.done       = (r_idx == 3'(C_NUM_CODES)) || r_nl_done;
    assign o_status.cand_valid = cand_valid;
    assign o_status.hold_valid = r_hold_valid;
    assign o_status.out_free   = out_free;
    assign o_out_valid         = r_out_valid;
    assign o_out               = r_out;

endmodule
`default_nettype wire

// File: src/sixbit_text_word_decoder_with_tabs_unit.sv
// Top level of the six-bit text word decoder with tab expansion.
// Instantiates sbtwd_ctrl and sbtwd_datapath; uses sbtwd_pkg.
//
// channel   dir  signals                      payload
// s_axis    in   tvalid tready tdata tuser    tdata[29:0] word, tuser line_start
// m_axis    out  tvalid tready tdata tuser    tdata char_code/column_after,
//                tlast                        tuser char_valid/newline_seen
// cfg       in   i_cfg_wr_en i_cfg_wr_data    expand_tabs
//
// A word passes through a load, a step for each code, an extra step for each
// expanded tab, a step for each padding space, end detection and a flush.
// Beats leave through a one-deep hold stage and the output register; with
// m_axis_tready low the sequencer stalls when a new beat finds both full,
// or when the flush finds the output register full.
// Reset is synchronous, active low: column 1, first stop 13, tab expansion on.
`default_nettype none
module sixbit_text_word_decoder_with_tabs_unit
    import sbtwd_pkg::*;
#(
    parameter int COLUMN_LIMIT = 255
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [31:0] s_axis_tdata,   // [29:0] word
    input  wire         s_axis_tuser,   // [0] line_start
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [6:0] char_code, [14:7] column_after
    output logic [1:0]  m_axis_tuser,   // [0] char_valid, [1] newline_seen
    output logic        m_axis_tlast,
    input  wire         i_cfg_wr_en,
    input  wire         i_cfg_wr_data
);

    t_ctrl_cmd  cmd;
    t_dp_status status;
    t_result    out_res;

    sbtwd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    sbtwd_datapath #(
        .COLUMN_LIMIT (COLUMN_LIMIT)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_word        (s_axis_tdata[C_WORD_W-1:0]),
        .i_line_start  (s_axis_tuser),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_out_ready   (m_axis_tready),
        .o_out_valid   (m_axis_tvalid),
        .o_out         (out_res)
    );

    assign m_axis_tdata = {1'b0, out_res.column_after, out_res.char_code};
    assign m_axis_tuser = {out_res.newline_seen, out_res.char_valid};
    assign m_axis_tlast = out_res.last;

endmodule
`default_nettype wire

// File: src/sbtwd_checker.sv
// Port-level checks for the six-bit text word decoder top level.
// Bound to sixbit_text_word_decoder_with_tabs_unit; no package needed.
`default_nettype none
module sbtwd_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        m_axis_tvalid,
    input wire        m_axis_tready,
    input wire [15:0] m_axis_tdata,
    input wire [1:0]  m_axis_tuser,
    input wire        m_axis_tlast
);

    // marker beat ends its word and carries no character
    a_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser[0]) |->
            (m_axis_tlast && !m_axis_tuser[1] && m_axis_tdata[6:0] == 7'h00))
        else $error("marker beat malformed");

    // newline ends the word at column 1
    a_newline: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[1]) |->
            (m_axis_tlast && m_axis_tuser[0] && m_axis_tdata[6:0] == 7'h0A
             && m_axis_tdata[14:7] == 8'd1))
        else $error("newline beat malformed");

    // no character beat before column 2
    a_column: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[0] && !m_axis_tuser[1]) |->
            (m_axis_tdata[14:7] != 8'd0 && m_axis_tdata[14:7] != 8'd1))
        else $error("character beat at start column");

    a_idle_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid right after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
             && $stable(m_axis_tlast)))
        else $error("stalled beat changed");

endmodule

bind sixbit_text_word_decoder_with_tabs_unit sbtwd_checker u_sbtwd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
`default_nettype wire
